// ----- rtl/sharp_pkg.sv -----
`default_nettype none
// Shared types and constants of the 3x3 cross-kernel sharpening unit.
// Used by every module in rtl/; depends on nothing.
package sharp_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 11;
  localparam int CHAN_W       = 2;
  localparam int WIDTH_CFG_W  = 12;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CHANS_CFG_W  = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int IDX_W        = 13;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_PAD_W    = OUT_TDATA_W - (SAMPLE_W + ROW_W + COL_W + CHAN_W);

  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_RST    = 640;
  localparam int HEIGHT_RST   = 480;
  localparam int CHANS_RST    = 3;

  localparam int Q_DEPTH      = 8;
  localparam int Q_CNT_W      = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAN_W-1:0] chan;
    logic              last;
  } pos_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] centre;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] down;
  } taps_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sharpened;
    pos_t                pos;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/sharp_linemem.sv -----
`default_nettype none
// Line store: one write port and two read ports, read data registered.
// Uses sharp_pkg for the sample width.
module sharp_linemem #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  wire                              clk,
  input  wire                              wr_en,
  input  wire [ADDR_W-1:0]                 wr_addr,
  input  wire [sharp_pkg::SAMPLE_W-1:0]    wr_data,
  input  wire [ADDR_W-1:0]                 rd_addr_a,
  input  wire [ADDR_W-1:0]                 rd_addr_b,
  output logic [sharp_pkg::SAMPLE_W-1:0]   rd_data_a,
  output logic [sharp_pkg::SAMPLE_W-1:0]   rd_data_b
);

  logic [sharp_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
`default_nettype wire

// ----- rtl/sharp_stencil.sv -----
`default_nettype none
// Kernel arithmetic: 5*centre minus the four neighbors, then clamp to 0..255.
// One register stage; uses sharp_pkg types.
module sharp_stencil (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  sharp_pkg::taps_t     taps,
  input  sharp_pkg::pos_t      pos,
  output logic                 out_valid,
  output sharp_pkg::result_t   result
);

  logic                  valid_r;
  logic [10:0]           gain_r;
  logic [9:0]            sum_r;
  sharp_pkg::pos_t       pos_r;
  logic [10:0]           gain_nxt;
  logic [9:0]            sum_nxt;
  logic signed [11:0]    diff;

  always_comb begin
    gain_nxt = {1'b0, taps.centre, 2'b00} + {3'b000, taps.centre};
    sum_nxt  = {2'b00, taps.up} + {2'b00, taps.down} + {2'b00, taps.left}
             + {2'b00, taps.right};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    gain_r <= gain_nxt;
    sum_r  <= sum_nxt;
    pos_r  <= pos;
  end

  always_comb begin
    diff = $signed({1'b0, gain_r}) - $signed({2'b00, sum_r});
    result.pos = pos_r;
    if (diff < 12'sd0) begin
      result.sharpened = '0;
    end else if (diff > 12'sd255) begin
      result.sharpened = '1;
    end else begin
      result.sharpened = diff[sharp_pkg::SAMPLE_W-1:0];
    end
  end

  assign out_valid = valid_r;

endmodule
`default_nettype wire

// ----- rtl/sharp_qcell.sv -----
`default_nettype none
// One cell of the result queue: holds a result, shifts toward the head on a pop.
// Uses sharp_pkg::result_t.
module sharp_qcell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire                  pop,
  input  sharp_pkg::result_t   push_data,
  input  wire                  prev_valid,
  input  wire                  next_valid,
  input  sharp_pkg::result_t   next_data,
  output logic                 valid,
  output sharp_pkg::result_t   data
);

  logic                valid_r;
  logic                valid_nxt;
  sharp_pkg::result_t  data_r;
  sharp_pkg::result_t  data_nxt;
  logic                load_push;

  always_comb begin
    load_push = push && (pop ? (valid_r && !next_valid) : (!valid_r && prev_valid));
    if (load_push) begin
      valid_nxt = 1'b1;
      data_nxt  = push_data;
    end else if (pop) begin
      valid_nxt = next_valid;
      data_nxt  = next_data;
    end else begin
      valid_nxt = valid_r;
      data_nxt  = data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule
`default_nettype wire

// ----- rtl/sharpen_3x3_stencil_unit.sv -----
`default_nettype none
// Top level of the 3x3 cross-kernel sharpening unit.
// Uses sharp_pkg, sharp_linemem, sharp_stencil and sharp_qcell.
//
//  port group  dir  contents
//  in_*        in   tdata[7:0] sample; tuser frame_start
//  out_*       out  tdata sharpened, row, column, channel; tlast frame_last
//  cfg_*       in   wr_en, index (0 width, 1 height, 2 channels), wr_data
//
// One request per cycle while in_tready is high; a result passes the read stage, the kernel register and a queue cell.
// Each line store takes one write and two reads per cycle, which sets that pace.
// Reset clears the position counters, pipeline valids and the queue, and loads the config defaults.
// in_tready drops while queued plus in-flight results would fill the 8-cell queue.
module sharpen_3x3_stencil_unit #(
  parameter int MAX_WIDTH    = 2048,
  parameter int MAX_CHANNELS = 4
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire [sharp_pkg::IN_TDATA_W-1:0]      in_tdata,    // [7:0] sample
  input  wire                                  in_tuser,    // frame_start
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [7:0] sharpened, [19:8] out_row, [30:20] out_column, [32:31] out_channel
  output logic [sharp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tlast,   // frame_last
  input  wire                                  cfg_wr_en,
  input  wire [sharp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [sharp_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

  localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int W_RST      = (sharp_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                              : sharp_pkg::WIDTH_RST;
  localparam int H_RST      = (sharp_pkg::HEIGHT_RST > sharp_pkg::MAX_HEIGHT)
                              ? sharp_pkg::MAX_HEIGHT : sharp_pkg::HEIGHT_RST;
  localparam int C_RST      = (sharp_pkg::CHANS_RST > MAX_CHANNELS) ? MAX_CHANNELS
                              : sharp_pkg::CHANS_RST;

  localparam int WW = sharp_pkg::WIDTH_CFG_W;
  localparam int HW = sharp_pkg::HEIGHT_CFG_W;
  localparam int CW = sharp_pkg::CHANS_CFG_W;
  localparam int RW = sharp_pkg::ROW_W;
  localparam int LW = sharp_pkg::COL_W;
  localparam int KW = sharp_pkg::CHAN_W;
  localparam int IW = sharp_pkg::IDX_W;
  localparam int QD = sharp_pkg::Q_DEPTH;
  localparam int SW = sharp_pkg::SAMPLE_W;

  // configuration, held already clamped
  logic [WW-1:0] w_r, w_nxt, wl_r, wl_nxt;
  logic [HW-1:0] h_r, h_nxt, hl_r, hl_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [KW-1:0] cl_r, cl_nxt;
  logic [WW-1:0] w_raw, w_clamp;
  logic [HW-1:0] h_raw, h_clamp;
  logic [CW-1:0] c_raw, c_clamp;

  always_comb begin
    w_raw = cfg_wr_data[WW-1:0];
    h_raw = cfg_wr_data[HW-1:0];
    c_raw = cfg_wr_data[CW-1:0];
    if (w_raw < WW'(3)) begin
      w_clamp = WW'(3);
    end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    if (h_raw < HW'(3)) begin
      h_clamp = HW'(3);
    end else if (32'(h_raw) > 32'(sharp_pkg::MAX_HEIGHT)) begin
      h_clamp = HW'(sharp_pkg::MAX_HEIGHT);
    end else begin
      h_clamp = h_raw;
    end
    if (c_raw < CW'(1)) begin
      c_clamp = CW'(1);
    end else if (32'(c_raw) > 32'(MAX_CHANNELS)) begin
      c_clamp = CW'(MAX_CHANNELS);
    end else begin
      c_clamp = c_raw;
    end
  end

  always_comb begin
    w_nxt  = w_r;
    wl_nxt = wl_r;
    h_nxt  = h_r;
    hl_nxt = hl_r;
    c_nxt  = c_r;
    cl_nxt = cl_r;
    if (cfg_wr_en) begin
      unique case (sharp_pkg::cfg_idx_t'(cfg_index))
        sharp_pkg::CFG_IMAGE_WIDTH: begin
          w_nxt  = w_clamp;
          wl_nxt = w_clamp - WW'(2);
        end
        sharp_pkg::CFG_IMAGE_HEIGHT: begin
          h_nxt  = h_clamp;
          hl_nxt = h_clamp - HW'(1);
        end
        sharp_pkg::CFG_CHANNEL_COUNT: begin
          c_nxt  = c_clamp;
          cl_nxt = KW'(c_clamp - CW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= WW'(W_RST);
      wl_r <= WW'(W_RST - 2);
      h_r  <= HW'(H_RST);
      hl_r <= HW'(H_RST - 1);
      c_r  <= CW'(C_RST);
      cl_r <= KW'(C_RST - 1);
    end else begin
      w_r  <= w_nxt;
      wl_r <= wl_nxt;
      h_r  <= h_nxt;
      hl_r <= hl_nxt;
      c_r  <= c_nxt;
      cl_r <= cl_nxt;
    end
  end

  // position counters and request decode
  logic [RW-1:0] row_r, row_nxt, row_cur;
  logic [LW-1:0] col_r, col_nxt, col_cur;
  logic [KW-1:0] ch_r, ch_nxt, ch_cur;
  logic [CW-1:0] ch_inc;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;
  logic          ch_wrap, col_wrap, row_wrap;
  logic [IW-1:0] idx, col_x_c;
  logic          acc_emit, acc_wr_ok;
  logic [AW-1:0] addr0, addr_right, addr_left;
  sharp_pkg::pos_t acc_pos;
  logic          in_acc;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    row_cur  = in_tuser ? '0 : row_r;
    col_cur  = in_tuser ? '0 : col_r;
    ch_cur   = in_tuser ? '0 : ch_r;
    col_x_c  = IW'({2'b00, col_cur}) * IW'(c_r);
    idx      = col_x_c + IW'(ch_cur);
    acc_wr_ok = 32'(idx) < 32'(LINE_DEPTH);
    addr0      = AW'(idx);
    addr_right = AW'(idx + IW'(c_r));
    addr_left  = AW'(idx - IW'(c_r));
    acc_emit = (row_cur >= RW'(2)) && ({1'b0, row_cur} < h_r)
            && (col_cur != '0) && ({1'b0, col_cur} <= wl_r)
            && ({1'b0, ch_cur} < c_r);
    acc_pos.row  = row_cur - RW'(1);
    acc_pos.col  = col_cur;
    acc_pos.chan = ch_cur;
    acc_pos.last = ({1'b0, row_cur} == hl_r) && ({1'b0, col_cur} == wl_r)
                && (ch_cur == cl_r);
    ch_inc   = {1'b0, ch_cur} + CW'(1);
    col_inc  = {1'b0, col_cur} + WW'(1);
    row_inc  = {1'b0, row_cur} + HW'(1);
    ch_wrap  = ch_inc >= c_r;
    col_wrap = col_inc >= w_r;
    row_wrap = row_inc >= h_r;
    ch_nxt   = ch_wrap ? '0 : ch_inc[KW-1:0];
    col_nxt  = col_cur;
    row_nxt  = row_cur;
    if (ch_wrap) begin
      col_nxt = col_wrap ? '0 : col_inc[LW-1:0];
      if (col_wrap) begin
        row_nxt = row_wrap ? '0 : row_inc[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      ch_r  <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      ch_r  <= ch_nxt;
    end
  end

  // read stage: line store data arrive in the cycle after the request
  logic            s1_valid_r, s1_emit_r, s1_wr_ok_r;
  logic [AW-1:0]   s1_addr_r;
  logic [SW-1:0]   s1_down_r, fwd_r;
  logic            hit_up_r, hit_left_r, hit_up_nxt, hit_left_nxt;
  sharp_pkg::pos_t s1_pos_r;
  logic [SW-1:0]   mid_c, mid_r, up_c, up_l;
  logic            up_wr_en;

  assign up_wr_en     = s1_valid_r && s1_wr_ok_r;
  assign hit_up_nxt   = up_wr_en && (s1_addr_r == addr0);
  assign hit_left_nxt = up_wr_en && (s1_addr_r == addr_left);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      s1_emit_r  <= in_acc && acc_emit;
    end
  end

  always_ff @(posedge clk) begin
    s1_wr_ok_r <= acc_wr_ok;
    s1_addr_r  <= addr0;
    s1_down_r  <= in_tdata[SW-1:0];
    s1_pos_r   <= acc_pos;
    hit_up_r   <= hit_up_nxt;
    hit_left_r <= hit_left_nxt;
    fwd_r      <= mid_c;
  end

  sharp_linemem #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (AW)
  ) u_mid_store (
    .clk       (clk),
    .wr_en     (in_acc && acc_wr_ok),
    .wr_addr   (addr0),
    .wr_data   (in_tdata[SW-1:0]),
    .rd_addr_a (addr0),
    .rd_addr_b (addr_right),
    .rd_data_a (mid_c),
    .rd_data_b (mid_r)
  );

  sharp_linemem #(
    .DEPTH  (LINE_DEPTH),
    .ADDR_W (AW)
  ) u_up_store (
    .clk       (clk),
    .wr_en     (up_wr_en),
    .wr_addr   (s1_addr_r),
    .wr_data   (mid_c),
    .rd_addr_a (addr0),
    .rd_addr_b (addr_left),
    .rd_data_a (up_c),
    .rd_data_b (up_l)
  );

  sharp_pkg::taps_t   taps;
  sharp_pkg::result_t s2_result;
  logic               s2_valid;

  always_comb begin
    taps.up     = hit_up_r ? fwd_r : up_c;
    taps.left   = hit_left_r ? fwd_r : up_l;
    taps.centre = mid_c;
    taps.right  = mid_r;
    taps.down   = s1_down_r;
  end

  sharp_stencil u_stencil (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_emit_r),
    .taps      (taps),
    .pos       (s1_pos_r),
    .out_valid (s2_valid),
    .result    (s2_result)
  );

  // result queue: a row of cells, head at cell 0
  logic [QD-1:0]      q_valid, q_prev_valid, q_next_valid;
  sharp_pkg::result_t q_data [QD];
  sharp_pkg::result_t q_next_data [QD];
  logic               q_pop;
  logic [sharp_pkg::Q_CNT_W-1:0] q_cnt, credit_used;

  assign q_pop        = q_valid[0] && out_tready;
  assign q_prev_valid = {q_valid[QD-2:0], 1'b1};
  assign q_next_valid = {1'b0, q_valid[QD-1:1]};

  for (genvar i = 0; i < QD; i++) begin : g_qcell
    if (i == QD - 1) begin : g_tail
      assign q_next_data[i] = '0;
    end else begin : g_body
      assign q_next_data[i] = q_data[i+1];
    end
    sharp_qcell u_qcell (
      .clk        (clk),
      .rst_n      (rst_n),
      .push       (s2_valid),
      .pop        (q_pop),
      .push_data  (s2_result),
      .prev_valid (q_prev_valid[i]),
      .next_valid (q_next_valid[i]),
      .next_data  (q_next_data[i]),
      .valid      (q_valid[i]),
      .data       (q_data[i])
    );
  end

  always_comb begin
    q_cnt       = sharp_pkg::Q_CNT_W'($countones(q_valid));
    credit_used = q_cnt + sharp_pkg::Q_CNT_W'(s1_emit_r) + sharp_pkg::Q_CNT_W'(s2_valid);
  end

  assign in_tready  = rst_n && (credit_used < sharp_pkg::Q_CNT_W'(QD));
  assign out_tvalid = q_valid[0];
  assign out_tdata  = {{sharp_pkg::OUT_PAD_W{1'b0}}, q_data[0].pos.chan,
                       q_data[0].pos.col, q_data[0].pos.row, q_data[0].sharpened};
  assign out_tlast  = q_data[0].pos.last;

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_valid && (&q_valid) && !q_pop))
    else $error("result queue overflow");

  a_queue_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid & (q_valid + QD'(1))) == '0)
    else $error("result queue cells not packed toward the head");

  a_emit_reaches_stencil: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && acc_emit) |=> (s1_valid_r && s1_emit_r))
    else $error("emitting request lost before the kernel stage");

  a_result_pushed: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_emit_r) |=> s2_valid)
    else $error("kernel stage dropped a result");
`endif

endmodule
`default_nettype wire
